FILE: rtl/core/smp_pkg.sv
package smp_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_BITS      = 24;
    localparam int CORDIC_STEPS  = 30;
    localparam int QUO_BITS      = OUT_BITS + 1;
    localparam int CW            = 34;
    localparam int DEN_W         = 36;
    localparam int NUM_W         = 35;
    localparam int REM_W         = NUM_W + OUT_FRAC_BITS + 1;
    localparam int SH_W          = 5;

    localparam logic [0:0] CFG_CENTER_LAT = 1'b0;
    localparam logic [0:0] CFG_CENTER_LON = 1'b1;

    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [DEN_W-1:0] ONE_Q30 = 36'sd1073741824;
    localparam logic signed [DEN_W-1:0] SAT_LIM = DEN_W'(64'sd1 <<< (30 - OUT_FRAC_BITS));

    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // one rotation lane: vector, residual angle, quadrant
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           q;
    } t_clane;

    // lanes: 0 point latitude, 1 center latitude, 2 longitude difference
    typedef struct packed {
        logic            vld;
        t_clane [2:0]    lane;
    } t_cstage;

    // one divider lane: partial remainder, quotient bits, divisor
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [QUO_BITS-1:0] quo;
        logic [DEN_W-1:0]    den;
    } t_dlane;

    // Q30 product, floor shift
    function automatic logic signed [CW-1:0] mulq(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b;
        return p[CW+29:30];
    endfunction

endpackage

FILE: rtl/core/stereographic_map_projection_top.sv
// Throughput: one request per cycle; busy is never raised.
// The pipeline is a 30-cell CORDIC chain, five quadrant/product/sum/setup stages,
// a 25-cell divider chain and the output register.
// Reset (i_rst_n low, synchronous) clears all valid bits and both center registers.
// The receiver cannot stall: each result is shown for exactly one cycle.
module stereographic_map_projection_top
    import smp_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [ANGLE_BITS-1:0] i_point_lat,
    input  logic signed [ANGLE_BITS-1:0] i_point_lon,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [0:0]                   i_cfg_index,
    input  logic [ANGLE_BITS-1:0]        i_cfg_data,
    output logic                         o_done,
    output logic signed [OUT_BITS-1:0]   o_map_x,
    output logic signed [OUT_BITS-1:0]   o_map_y,
    output logic                         o_saturated
);

    typedef struct packed {
        logic vld;
        logic sat;
        logic negx;
        logic negy;
    } t_side;

    logic [ANGLE_BITS-1:0] r_center_lat;
    logic [ANGLE_BITS-1:0] r_center_lon;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_lat <= '0;
            r_center_lon <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CENTER_LAT: r_center_lat <= i_cfg_data;
                CFG_CENTER_LON: r_center_lon <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // angle to quadrant and residual
    function automatic t_clane prep(input logic [ANGLE_BITS-1:0] ang);
        logic [31:0] ph;
        logic [31:0] php;
        logic [31:0] r;
        t_clane      l;
        ph   = {ang, {(32-ANGLE_BITS){1'b0}}};
        php  = ph + 32'h2000_0000;
        l.q  = php[31:30];
        r    = ph - {l.q, 30'b0};
        l.z  = {{(CW-32){r[31]}}, r};
        l.x  = CORDIC_X0;
        l.y  = '0;
        return l;
    endfunction

    t_cstage w_c [0:CORDIC_STEPS];
    t_cstage w_c0;

    always_comb begin
        logic [ANGLE_BITS-1:0] dl;
        dl = i_point_lon - r_center_lon;
        w_c0.vld     = start;
        w_c0.lane[0] = prep(i_point_lat);
        w_c0.lane[1] = prep(r_center_lat);
        w_c0.lane[2] = prep(dl);
    end

    assign w_c[0] = w_c0;

    // CORDIC chain
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        smp_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SH_W'(g)),
            .i_d     (w_c[g]),
            .o_q     (w_c[g+1])
        );
    end

    // quadrant rotation
    logic                 r_rv;
    logic signed [CW-1:0] r_s [0:2];
    logic signed [CW-1:0] r_c [0:2];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            case (w_c[CORDIC_STEPS].lane[l].q)
                2'd0: begin
                    r_c[l] <= w_c[CORDIC_STEPS].lane[l].x;
                    r_s[l] <= w_c[CORDIC_STEPS].lane[l].y;
                end
                2'd1: begin
                    r_c[l] <= -w_c[CORDIC_STEPS].lane[l].y;
                    r_s[l] <= w_c[CORDIC_STEPS].lane[l].x;
                end
                2'd2: begin
                    r_c[l] <= -w_c[CORDIC_STEPS].lane[l].x;
                    r_s[l] <= -w_c[CORDIC_STEPS].lane[l].y;
                end
                default: begin
                    r_c[l] <= w_c[CORDIC_STEPS].lane[l].y;
                    r_s[l] <= -w_c[CORDIC_STEPS].lane[l].x;
                end
            endcase
        end
        r_rv <= i_rst_n & w_c[CORDIC_STEPS].vld;
    end

    // first products
    logic                 r_m1v;
    logic signed [CW-1:0] r_p1, r_p2, r_p3, r_p4, r_p5, r_cd;

    always_ff @(posedge i_clk) begin
        r_p1  <= mulq(r_s[0], r_s[1]);
        r_p2  <= mulq(r_c[1], r_c[0]);
        r_p3  <= mulq(r_c[0], r_s[2]);
        r_p4  <= mulq(r_s[0], r_c[1]);
        r_p5  <= mulq(r_c[0], r_s[1]);
        r_cd  <= r_c[2];
        r_m1v <= i_rst_n & r_rv;
    end

    // second products
    logic                 r_m2v;
    logic signed [CW-1:0] r_q1, r_q3, r_q4, r_p6, r_p7;

    always_ff @(posedge i_clk) begin
        r_p6  <= mulq(r_p2, r_cd);
        r_p7  <= mulq(r_p5, r_cd);
        r_q1  <= r_p1;
        r_q3  <= r_p3;
        r_q4  <= r_p4;
        r_m2v <= i_rst_n & r_m1v;
    end

    // denominator and numerators
    logic                    r_m3v;
    logic signed [DEN_W-1:0] r_den;
    logic signed [NUM_W-1:0] r_nx, r_ny;

    always_ff @(posedge i_clk) begin
        r_den <= ONE_Q30 + DEN_W'(r_q1) + DEN_W'(r_p6);
        r_nx  <= NUM_W'(r_q3);
        r_ny  <= NUM_W'(r_q4) - NUM_W'(r_p7);
        r_m3v <= i_rst_n & r_m2v;
    end

    // divider setup: magnitudes, signs, antipode test
    t_dlane w_dx [0:QUO_BITS];
    t_dlane w_dy [0:QUO_BITS];
    t_side  w_sd [0:QUO_BITS];
    t_dlane r_sux, r_suy;
    t_side  r_susd;

    always_ff @(posedge i_clk) begin
        logic [NUM_W-1:0] mx;
        logic [NUM_W-1:0] my;
        mx = r_nx[NUM_W-1] ? NUM_W'(-r_nx) : NUM_W'(r_nx);
        my = r_ny[NUM_W-1] ? NUM_W'(-r_ny) : NUM_W'(r_ny);
        r_sux.rem   <= {mx, {(OUT_FRAC_BITS+1){1'b0}}};
        r_suy.rem   <= {my, {(OUT_FRAC_BITS+1){1'b0}}};
        r_sux.quo   <= '0;
        r_suy.quo   <= '0;
        r_sux.den   <= r_den;
        r_suy.den   <= r_den;
        r_susd.sat  <= r_den < SAT_LIM;
        r_susd.negx <= r_nx[NUM_W-1];
        r_susd.negy <= r_ny[NUM_W-1];
        r_susd.vld  <= i_rst_n & r_m3v;
    end

    assign w_dx[0] = r_sux;
    assign w_dy[0] = r_suy;
    assign w_sd[0] = r_susd;

    // divider chain, most significant quotient bit first
    for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
        t_side r_sd;

        smp_div_cell u_dx (
            .i_clk (i_clk),
            .i_k   (SH_W'(QUO_BITS - 1 - j)),
            .i_d   (w_dx[j]),
            .o_q   (w_dx[j+1])
        );

        smp_div_cell u_dy (
            .i_clk (i_clk),
            .i_k   (SH_W'(QUO_BITS - 1 - j)),
            .i_d   (w_dy[j]),
            .o_q   (w_dy[j+1])
        );

        always_ff @(posedge i_clk) begin
            r_sd <= {w_sd[j].vld & i_rst_n, w_sd[j].sat, w_sd[j].negx, w_sd[j].negy};
        end

        assign w_sd[j+1] = r_sd;
    end

    // clamp one lane to the signed output range
    function automatic logic [OUT_BITS-1:0] clamp(input logic [QUO_BITS-1:0] quo,
                                                  input logic neg, input logic sat);
        logic [OUT_BITS-1:0] mag;
        logic                ovf;
        mag = quo[OUT_BITS-1:0];
        ovf = quo[QUO_BITS-1];
        if (neg) begin
            if (sat || ovf || (mag[OUT_BITS-1] && (mag[OUT_BITS-2:0] != '0))) begin
                return {1'b1, {(OUT_BITS-1){1'b0}}};
            end
            return -mag;
        end
        if (sat || ovf || mag[OUT_BITS-1]) begin
            return {1'b0, {(OUT_BITS-1){1'b1}}};
        end
        return mag;
    endfunction

    // output register
    always_ff @(posedge i_clk) begin
        o_map_x     <= clamp(w_dx[QUO_BITS].quo, w_sd[QUO_BITS].negx, w_sd[QUO_BITS].sat);
        o_map_y     <= clamp(w_dy[QUO_BITS].quo, w_sd[QUO_BITS].negy, w_sd[QUO_BITS].sat);
        o_saturated <= w_sd[QUO_BITS].sat;
        o_done      <= i_rst_n & w_sd[QUO_BITS].vld;
    end

endmodule

FILE: rtl/core/smp_cordic_cell.sv
module smp_cordic_cell
    import smp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [SH_W-1:0] i_shift,
    input  t_cstage         i_d,
    output t_cstage         o_q
);

    t_cstage n_q;
    t_cstage r_q;

    // one micro-rotation on each lane
    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        n_q     = i_d;
        n_q.vld = i_d.vld & i_rst_n;
        at      = $signed({2'b00, ATAN_TAB[i_shift]});
        for (int l = 0; l < 3; l++) begin
            dx = i_d.lane[l].y >>> i_shift;
            dy = i_d.lane[l].x >>> i_shift;
            if (!i_d.lane[l].z[CW-1]) begin
                n_q.lane[l].x = i_d.lane[l].x - dx;
                n_q.lane[l].y = i_d.lane[l].y + dy;
                n_q.lane[l].z = i_d.lane[l].z - at;
            end else begin
                n_q.lane[l].x = i_d.lane[l].x + dx;
                n_q.lane[l].y = i_d.lane[l].y - dy;
                n_q.lane[l].z = i_d.lane[l].z + at;
            end
        end
    end

    // valid bit cleared by reset through n_q
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/smp_div_cell.sv
module smp_div_cell
    import smp_pkg::*;
(
    input  logic            i_clk,
    input  logic [SH_W-1:0] i_k,
    input  t_dlane          i_d,
    output t_dlane          o_q
);

    localparam int CMP_W = DEN_W + QUO_BITS + 1;

    t_dlane r_q;
    t_dlane n_q;

    // one restoring quotient bit
    always_comb begin
        logic [CMP_W-1:0] dsh;
        logic             ge;
        dsh = {{(QUO_BITS+1){1'b0}}, i_d.den} << i_k;
        ge  = {{(CMP_W-REM_W){1'b0}}, i_d.rem} >= dsh;
        n_q = i_d;
        if (ge) begin
            n_q.rem = i_d.rem - dsh[REM_W-1:0];
        end
        n_q.quo = i_d.quo | (QUO_BITS'(ge) << i_k);
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule
